>>> src/sg3_pkg.sv
// Shared types and constants for the soft G3 power-on sequencer.
// No dependencies; every module of the block and the testbench import this package.
package sg3_pkg;

  localparam int unsigned TimerW   = 16;
  localparam int unsigned ElapsedW = 17;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [ElapsedW-1:0] ElapsedMax = {ElapsedW{1'b1}};

  // Reset values of the configuration registers
  localparam logic              RstFitted     = 1'b1;
  localparam logic [TimerW-1:0] RstApTimeout  = 16'd15000;
  localparam logic [TimerW-1:0] RstApPoll     = 16'd100;
  localparam logic [TimerW-1:0] RstPciePulse  = 16'd10;
  localparam logic [TimerW-1:0] RstButtonDly  = 16'd10000;
  localparam logic              RstSg3Active  = 1'b1;
  localparam logic              RstPcieActive = 1'b0;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FITTED      = 3'd0,
    REG_AP_TIMEOUT  = 3'd1,
    REG_AP_POLL     = 3'd2,
    REG_PCIE_PULSE  = 3'd3,
    REG_BUTTON_DLY  = 3'd4,
    REG_SG3_ACTIVE  = 3'd5,
    REG_PCIE_ACTIVE = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_ON    = 2'd1,
    ACT_DOWN  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_WAIT_AP = 2'd1,
    PH_PULSE   = 2'd2,
    PH_BUTTON  = 2'd3
  } phase_e;

  typedef struct packed {
    logic              fitted;
    logic [TimerW-1:0] ap_timeout;
    logic [TimerW-1:0] ap_poll;
    logic [TimerW-1:0] pcie_pulse;
    logic [TimerW-1:0] button_dly;
    logic              sg3_active;
    logic              pcie_active;
  } cfg_t;

  typedef struct packed {
    logic [1:0] action;
    logic       power_good;
    logic       ap_reset_level;
  } item_t;

  typedef struct packed {
    logic   soft_g3_pin;
    logic   pcie_reset_pin;
    logic   button_request;
    logic   power_off_notice;
    logic   timeout_error;
    phase_e phase;
  } res_t;

  function automatic logic [TimerW-1:0] min16(input logic [TimerW-1:0] a,
                                              input logic [TimerW-1:0] b);
    min16 = (a < b) ? a : b;
  endfunction

endpackage

>>> src/sg3_in_if.sv
// Input channel of the sequencer: valid/ready plus one request item.
// Depends on nothing.
interface sg3_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic       power_good;
  logic       ap_reset_level;

  modport source(output valid, output action, output power_good,
                 output ap_reset_level, input ready);
  modport sink(input valid, input action, input power_good,
               input ap_reset_level, output ready);
endinterface

>>> src/sg3_out_if.sv
// Result channel of the sequencer: valid/ready plus one result item.
// Depends on nothing.
interface sg3_out_if;
  logic       valid;
  logic       ready;
  logic       soft_g3_pin;
  logic       pcie_reset_pin;
  logic       button_request;
  logic       power_off_notice;
  logic       timeout_error;
  logic [1:0] phase;

  modport source(output valid, output soft_g3_pin, output pcie_reset_pin,
                 output button_request, output power_off_notice,
                 output timeout_error, output phase, input ready);
  modport sink(input valid, input soft_g3_pin, input pcie_reset_pin,
               input button_request, input power_off_notice,
               input timeout_error, input phase, output ready);
endinterface

>>> src/soft_g3_power_on_sequencer.sv
// Top level of the soft G3 power-on sequencer.
// Depends on sg3_pkg, sg3_in_if, sg3_out_if, sg3_cfg_regs and sg3_core.
//
// Usage:
// - in_i carries one transaction per millisecond tick, power-on request or
//   power-down request, with the sampled power-good and AP reset levels.
// - out_o returns exactly one result per input transaction, in order: the
//   pin levels after the transaction, the button/notice/timeout flags and
//   the sequencer phase.
// - cfg_we_i/cfg_idx_i/cfg_wdata_i write the seven configuration registers;
//   write only while no transaction is in flight.
// From input acceptance to result valid, a transaction passes the input
//   register and then the result register, which loads the result of the
//   state update computed in one pass.
// Throughput is one transaction per cycle while the receiver keeps ready high;
//   the state update is a handful of 16/17-bit decrements and compares, all combinational.
// Reset puts the sequencer idle with the stored soft G3 level low, PCIe
//   reset level high and the configuration at its defaults.
// When the receiver stalls, the result register holds; the input register
//   still takes one more transaction, then ready drops until the result
//   drains.
module soft_g3_power_on_sequencer import sg3_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  sg3_in_if.sink              in_i,
  sg3_out_if.source           out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t  cfg;
  item_t item_q;
  logic  in_vld_q;
  logic  out_vld_q;
  res_t  res_q;
  res_t  res;
  logic  advance;

  sg3_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Advance the held transaction into the result register when it is free
  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.action         <= in_i.action;
      item_q.power_good     <= in_i.power_good;
      item_q.ap_reset_level <= in_i.ap_reset_level;
    end
  end

  // State commits only when the transaction moves on
  sg3_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.soft_g3_pin      = res_q.soft_g3_pin;
  assign out_o.pcie_reset_pin   = res_q.pcie_reset_pin;
  assign out_o.button_request   = res_q.button_request;
  assign out_o.power_off_notice = res_q.power_off_notice;
  assign out_o.timeout_error    = res_q.timeout_error;
  assign out_o.phase            = res_q.phase;

endmodule

>>> src/sg3_cfg_regs.sv
// Configuration register bank of the sequencer, write-only.
// Depends on sg3_pkg.
module sg3_cfg_regs import sg3_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fitted      <= RstFitted;
      cfg_q.ap_timeout  <= RstApTimeout;
      cfg_q.ap_poll     <= RstApPoll;
      cfg_q.pcie_pulse  <= RstPciePulse;
      cfg_q.button_dly  <= RstButtonDly;
      cfg_q.sg3_active  <= RstSg3Active;
      cfg_q.pcie_active <= RstPcieActive;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_FITTED:      cfg_q.fitted      <= cfg_wdata_i[0];
        REG_AP_TIMEOUT:  cfg_q.ap_timeout  <= cfg_wdata_i;
        REG_AP_POLL:     cfg_q.ap_poll     <= cfg_wdata_i;
        REG_PCIE_PULSE:  cfg_q.pcie_pulse  <= cfg_wdata_i;
        REG_BUTTON_DLY:  cfg_q.button_dly  <= cfg_wdata_i;
        REG_SG3_ACTIVE:  cfg_q.sg3_active  <= cfg_wdata_i[0];
        REG_PCIE_ACTIVE: cfg_q.pcie_active <= cfg_wdata_i[0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/sg3_core.sv
// Sequencer state and the single-pass update applied per transaction.
// Depends on sg3_pkg.
module sg3_core import sg3_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  step_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output res_t  res_o
);

  phase_e              phase_q, phase_d;
  logic [TimerW-1:0]   timer_q, timer_d;
  logic [ElapsedW-1:0] elapsed_q, elapsed_d;
  logic                sg3_q, sg3_d;
  logic                pcie_q, pcie_d;

  logic                is_on, is_down, is_tick;
  logic                direct_button;
  logic [ElapsedW-1:0] elapsed_inc;
  logic [TimerW-1:0]   timer_dec;
  logic                fire, ap_released, timed_out;
  logic                flag_button, flag_notice, flag_tmo;

  always_comb begin
    is_on   = 1'b0;
    is_down = 1'b0;
    is_tick = 1'b0;
    case (action_e'(item_i.action))
      ACT_TICK: is_tick = (phase_q != PH_IDLE);
      ACT_ON:   is_on   = 1'b1;
      ACT_DOWN: is_down = 1'b1;
      default:  ; // unknown action: leave everything alone
    endcase
  end

  assign direct_button = !cfg_i.fitted || item_i.power_good;
  assign elapsed_inc   = (phase_q == PH_WAIT_AP && elapsed_q != ElapsedMax)
                         ? elapsed_q + 1'b1 : elapsed_q;
  assign timer_dec     = (timer_q != '0) ? timer_q - 1'b1 : timer_q;
  assign fire          = (timer_dec == '0);
  assign ap_released   = item_i.ap_reset_level;
  assign timed_out     = (elapsed_inc >= {1'b0, cfg_i.ap_timeout});

  // Next state
  always_comb begin
    phase_d   = phase_q;
    timer_d   = timer_q;
    elapsed_d = elapsed_q;
    sg3_d     = sg3_q;
    pcie_d    = pcie_q;
    if (step_i) begin
      if (is_on) begin
        if (!direct_button) begin
          sg3_d     = ~cfg_i.sg3_active;
          phase_d   = PH_WAIT_AP;
          elapsed_d = '0;
          timer_d   = min16(cfg_i.ap_poll, cfg_i.ap_timeout);
        end
      end else if (is_down) begin
        if (cfg_i.fitted) begin
          sg3_d  = cfg_i.sg3_active;
          pcie_d = cfg_i.pcie_active;
        end
      end else if (is_tick) begin
        elapsed_d = elapsed_inc;
        timer_d   = timer_dec;
        if (fire) begin
          unique case (phase_q)
            PH_WAIT_AP: begin
              if (ap_released) begin
                pcie_d  = 1'b0;
                phase_d = PH_PULSE;
                timer_d = cfg_i.pcie_pulse;
              end else if (timed_out) begin
                phase_d = PH_IDLE;
              end else begin
                // elapsed is below the timeout here, so the low 16 bits suffice
                timer_d = min16(cfg_i.ap_poll,
                                cfg_i.ap_timeout - elapsed_inc[TimerW-1:0]);
              end
            end
            PH_PULSE: begin
              pcie_d  = 1'b1;
              phase_d = PH_BUTTON;
              timer_d = cfg_i.button_dly;
            end
            PH_BUTTON: phase_d = PH_IDLE;
            default:   ;
          endcase
        end
      end
    end
  end

  // Per-transaction flags
  always_comb begin
    flag_button = 1'b0;
    flag_notice = 1'b0;
    flag_tmo    = 1'b0;
    if (is_on) begin
      flag_button = direct_button;
    end else if (is_down) begin
      flag_notice = 1'b1;
    end else if (is_tick && fire) begin
      flag_button = (phase_q == PH_BUTTON);
      flag_tmo    = (phase_q == PH_WAIT_AP) && !ap_released && timed_out;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      timer_q   <= '0;
      elapsed_q <= '0;
      sg3_q     <= 1'b0;
      pcie_q    <= 1'b1;
    end else begin
      phase_q   <= phase_d;
      timer_q   <= timer_d;
      elapsed_q <= elapsed_d;
      sg3_q     <= sg3_d;
      pcie_q    <= pcie_d;
    end
  end

  assign res_o.soft_g3_pin      = sg3_d;
  assign res_o.pcie_reset_pin   = pcie_d;
  assign res_o.button_request   = flag_button;
  assign res_o.power_off_notice = flag_notice;
  assign res_o.timeout_error    = flag_tmo;
  assign res_o.phase            = phase_d;

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for soft_g3_power_on_sequencer: directed and random
// request transactions, checked against an in-bench model of the sequencer.
// Depends on sg3_pkg, sg3_in_if, sg3_out_if and the sequencer RTL.

module tb_top;
  import sg3_pkg::*;

  // Margin after the pipeline drains, before a register write or the end check
  localparam int unsigned LatencyCycles = 4;
  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned RandomItems   = 900;
  localparam int unsigned ReportMax     = 10;
  localparam logic [1:0]  ActUnknown    = 2'd3;
  localparam logic [TimerW-1:0] TimerMax = {TimerW{1'b1}};

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = REG_FITTED;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  sg3_in_if  in_if ();
  sg3_out_if out_if ();

  soft_g3_power_on_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Model of the sequencer: its configuration and its state
  cfg_t                sq_cfg;
  phase_e              sq_phase;
  logic [TimerW-1:0]   sq_timer;
  logic [ElapsedW-1:0] sq_elapsed;
  logic                sq_g3_lvl;
  logic                sq_pcie_lvl;

  // Pin levels and flags predicted for every accepted request, oldest first
  res_t        pin_outcomes_q[$];
  res_t        next_want;
  int unsigned error_cnt = 0;
  int unsigned stall_cnt = 0;
  bit          gaps_on   = 1'b1;

  function automatic logic [TimerW-1:0] shorter_of(input logic [TimerW-1:0] a,
                                                   input logic [TimerW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  // Advance the model by one request and return the pins and flags it shows
  function automatic res_t sequencer_step(input item_t it);
    res_t r;
    logic btn;
    logic ntc;
    logic tmo;
    btn = 1'b0;
    ntc = 1'b0;
    tmo = 1'b0;
    case (it.action)
      ACT_ON: begin
        if (!sq_cfg.fitted || it.power_good) begin
          // Nothing to sequence: ask for the button right away, phase untouched
          btn = 1'b1;
        end else begin
          // Release soft G3 and (re)start the AP reset wait
          sq_g3_lvl  = ~sq_cfg.sg3_active;
          sq_phase   = PH_WAIT_AP;
          sq_elapsed = '0;
          sq_timer   = shorter_of(sq_cfg.ap_poll, sq_cfg.ap_timeout);
        end
      end
      ACT_DOWN: begin
        ntc = 1'b1;
        if (sq_cfg.fitted) begin
          sq_g3_lvl   = sq_cfg.sg3_active;
          sq_pcie_lvl = sq_cfg.pcie_active;
        end
      end
      ACT_TICK: begin
        if (sq_phase != PH_IDLE) begin
          if (sq_phase == PH_WAIT_AP && sq_elapsed != ElapsedMax) begin
            sq_elapsed = sq_elapsed + 1'b1;
          end
          if (sq_timer != '0) begin
            sq_timer = sq_timer - 1'b1;
          end
          if (sq_timer == '0) begin
            case (sq_phase)
              PH_WAIT_AP: begin
                if (it.ap_reset_level) begin
                  sq_pcie_lvl = 1'b0;
                  sq_phase    = PH_PULSE;
                  sq_timer    = sq_cfg.pcie_pulse;
                end else if (sq_elapsed >= {1'b0, sq_cfg.ap_timeout}) begin
                  sq_phase = PH_IDLE;
                  tmo      = 1'b1;
                end else begin
                  // elapsed is below the timeout here, so it fits the timer width
                  sq_timer = shorter_of(sq_cfg.ap_poll,
                                        sq_cfg.ap_timeout - sq_elapsed[TimerW-1:0]);
                end
              end
              PH_PULSE: begin
                sq_pcie_lvl = 1'b1;
                sq_phase    = PH_BUTTON;
                sq_timer    = sq_cfg.button_dly;
              end
              default: begin
                sq_phase = PH_IDLE;
                btn      = 1'b1;
              end
            endcase
          end
        end
      end
      default: begin
        // Unknown action: state untouched, all flags low
      end
    endcase
    r.soft_g3_pin      = sq_g3_lvl;
    r.pcie_reset_pin   = sq_pcie_lvl;
    r.button_request   = btn;
    r.power_off_notice = ntc;
    r.timeout_error    = tmo;
    r.phase            = sq_phase;
    return r;
  endfunction

  // Drive one request at the falling edge, hold it until a transaction
  // completes, then record its prediction
  task automatic send_item(input logic [1:0] act, input logic pg, input logic ap);
    item_t it;
    it.action         = act;
    it.power_good     = pg;
    it.ap_reset_level = ap;
    @(negedge clk_i);
    while (gaps_on && $urandom_range(99) < 7) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.action         <= it.action;
    in_if.power_good     <= it.power_good;
    in_if.ap_reset_level <= it.ap_reset_level;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    pin_outcomes_q.push_back(sequencer_step(it));
  endtask

  // Drop valid and hold until every predicted result has come back
  task automatic hold_until_drained();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pin_outcomes_q.size() != 0) @(posedge clk_i);
    repeat (LatencyCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_FITTED:      sq_cfg.fitted      = val[0];
      REG_AP_TIMEOUT:  sq_cfg.ap_timeout  = val;
      REG_AP_POLL:     sq_cfg.ap_poll     = val;
      REG_PCIE_PULSE:  sq_cfg.pcie_pulse  = val;
      REG_BUTTON_DLY:  sq_cfg.button_dly  = val;
      REG_SG3_ACTIVE:  sq_cfg.sg3_active  = val[0];
      REG_PCIE_ACTIVE: sq_cfg.pcie_active = val[0];
      default: ;
    endcase
  endtask

  // Drain the pipeline, then rewrite every register
  task automatic load_setup(input logic fitted, input logic [TimerW-1:0] timeout,
                            input logic [TimerW-1:0] poll,
                            input logic [TimerW-1:0] pulse,
                            input logic [TimerW-1:0] button,
                            input logic g3_act, input logic pcie_act);
    hold_until_drained();
    write_reg(REG_FITTED, {15'd0, fitted});
    write_reg(REG_AP_TIMEOUT, timeout);
    write_reg(REG_AP_POLL, poll);
    write_reg(REG_PCIE_PULSE, pulse);
    write_reg(REG_BUTTON_DLY, button);
    write_reg(REG_SG3_ACTIVE, {15'd0, g3_act});
    write_reg(REG_PCIE_ACTIVE, {15'd0, pcie_act});
  endtask

  // Mostly short durations so sequences finish; now and then zero or full scale
  function automatic logic [TimerW-1:0] pick_duration(input int unsigned typ_max);
    int unsigned r;
    r = $urandom_range(19);
    if (r == 0) return '0;
    if (r == 1) return TimerMax;
    return TimerW'($urandom_range(typ_max));
  endfunction

  // Defaults after reset: 100 ms poll, active-high soft G3, PCIe reset active low
  task automatic test_reset_values();
    send_item(ACT_ON, 1'b0, 1'b0);
    send_item(ACT_DOWN, 1'b0, 1'b1);
    send_item(ActUnknown, 1'b1, 1'b1);
    send_item(ACT_ON, 1'b1, 1'b0);
  endtask

  // Walk the whole path: poll miss, release, pulse, button delay, request
  task automatic test_full_sequence();
    load_setup(1'b1, 16'd3, 16'd2, 16'd1, 16'd1, 1'b0, 1'b1);
    send_item(ACT_ON, 1'b0, 1'b0);
    send_item(ACT_TICK, 1'b0, 1'b0);
    send_item(ACT_TICK, 1'b1, 1'b0);
    send_item(ACT_TICK, 1'b0, 1'b1);
    send_item(ACT_TICK, 1'b0, 1'b1);
    send_item(ACT_TICK, 1'b0, 1'b0);
  endtask

  // Restart mid-wait, power down while running, then let the AP wait expire
  task automatic test_ap_timeout();
    send_item(ACT_ON, 1'b0, 1'b0);
    send_item(ACT_TICK, 1'b0, 1'b0);
    send_item(ACT_ON, 1'b0, 1'b1);
    send_item(ACT_DOWN, 1'b1, 1'b0);
    send_item(ACT_TICK, 1'b0, 1'b0);
    send_item(ACT_TICK, 1'b0, 1'b0);
    send_item(ACT_TICK, 1'b0, 1'b0);
  endtask

  // Pins absent, then zero timeout, zero poll, zero pulse and zero delay
  task automatic test_zero_timers();
    load_setup(1'b0, 16'd3, 16'd2, 16'd1, 16'd1, 1'b1, 1'b0);
    send_item(ACT_ON, 1'b0, 1'b0);
    send_item(ACT_DOWN, 1'b0, 1'b0);
    load_setup(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0);
    send_item(ACT_ON, 1'b0, 1'b0);
    send_item(ACT_TICK, 1'b0, 1'b0);
    send_item(ACT_ON, 1'b0, 1'b0);
    send_item(ACT_TICK, 1'b0, 1'b1);
    send_item(ACT_TICK, 1'b0, 1'b0);
    send_item(ACT_TICK, 1'b0, 1'b0);
  endtask

  // Full-scale registers: nothing fires, the pins still follow the requests
  task automatic test_register_extremes();
    load_setup(1'b1, TimerMax, TimerMax, TimerMax, TimerMax, 1'b1, 1'b1);
    send_item(ACT_ON, 1'b0, 1'b1);
    send_item(ACT_TICK, 1'b0, 1'b1);
    send_item(ACT_TICK, 1'b1, 1'b1);
    send_item(ACT_DOWN, 1'b0, 1'b0);
  endtask

  // Stop sending until the result side is empty, then carry on
  task automatic test_pause_for_drain();
    repeat (16) send_item(2'($urandom_range(3)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
    hold_until_drained();
    repeat (16) send_item(2'($urandom_range(3)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
  endtask

  // Mostly complete power-on sequences with random content, some noise
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned batch;
    int unsigned ticks;
    int unsigned ap_pct;
    int unsigned k;
    sent  = 0;
    batch = 0;
    while (sent < RandomItems) begin
      if (batch % 5 == 0) begin
        load_setup($urandom_range(9) != 0, pick_duration(40), pick_duration(8),
                   pick_duration(6), pick_duration(12),
                   1'($urandom_range(1)), 1'($urandom_range(1)));
        // Run one setup in three with no idling on either side
        gaps_on = ((batch / 5) % 3 != 1);
      end
      if ($urandom_range(99) < 75) begin
        case ($urandom_range(2))
          0:       ap_pct = 0;
          1:       ap_pct = 8;
          default: ap_pct = 40;
        endcase
        ticks = $urandom_range(4, 60);
        send_item(ACT_ON, 1'b0, 1'($urandom_range(1)));
        repeat (ticks) begin
          k = $urandom_range(99);
          if (k < 3) begin
            send_item(ACT_DOWN, 1'($urandom_range(1)), 1'($urandom_range(1)));
          end else if (k < 5) begin
            send_item(ActUnknown, 1'($urandom_range(1)), 1'($urandom_range(1)));
          end else if (k < 6) begin
            send_item(ACT_ON, 1'($urandom_range(1)), 1'($urandom_range(1)));
          end else begin
            send_item(ACT_TICK, 1'($urandom_range(1)), $urandom_range(99) < ap_pct);
          end
        end
        sent += ticks + 1;
      end else begin
        repeat (8) send_item(2'($urandom_range(3)), 1'($urandom_range(1)),
                             1'($urandom_range(1)));
        sent += 8;
      end
      batch++;
    end
    gaps_on = 1'b1;
  endtask

  // Receiver: stall now and then while idling is on
  always @(negedge clk_i) begin
    out_if.ready <= !(gaps_on && $urandom_range(99) < 7);
  end

  // Compare each completed result with the oldest prediction
  always @(posedge clk_i) begin
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pin_outcomes_q.size() == 0) begin
        if (error_cnt < ReportMax) begin
          $display("%0t: result with nothing pending: g3=%b pcie=%b btn=%b ntc=%b tmo=%b ph=%0d",
                   $time, out_if.soft_g3_pin, out_if.pcie_reset_pin,
                   out_if.button_request, out_if.power_off_notice,
                   out_if.timeout_error, out_if.phase);
        end
        error_cnt++;
      end else begin
        next_want = pin_outcomes_q.pop_front();
        if (out_if.soft_g3_pin      !== next_want.soft_g3_pin      ||
            out_if.pcie_reset_pin   !== next_want.pcie_reset_pin   ||
            out_if.button_request   !== next_want.button_request   ||
            out_if.power_off_notice !== next_want.power_off_notice ||
            out_if.timeout_error    !== next_want.timeout_error    ||
            out_if.phase            !== next_want.phase) begin
          if (error_cnt < ReportMax) begin
            $display("%0t: mismatch want g3=%b pcie=%b btn=%b ntc=%b tmo=%b ph=%0d",
                     $time, next_want.soft_g3_pin, next_want.pcie_reset_pin,
                     next_want.button_request, next_want.power_off_notice,
                     next_want.timeout_error, next_want.phase);
            $display("%0t:          got  g3=%b pcie=%b btn=%b ntc=%b tmo=%b ph=%0d",
                     $time, out_if.soft_g3_pin, out_if.pcie_reset_pin,
                     out_if.button_request, out_if.power_off_notice,
                     out_if.timeout_error, out_if.phase);
          end
          error_cnt++;
        end
      end
    end
  end

  // Watchdog: give up after a long run of cycles with no transaction at all
  always @(posedge clk_i) begin
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
    if (stall_cnt >= StallLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    in_if.valid          = 1'b0;
    in_if.action         = ACT_TICK;
    in_if.power_good     = 1'b0;
    in_if.ap_reset_level = 1'b0;

    sq_cfg.fitted      = RstFitted;
    sq_cfg.ap_timeout  = RstApTimeout;
    sq_cfg.ap_poll     = RstApPoll;
    sq_cfg.pcie_pulse  = RstPciePulse;
    sq_cfg.button_dly  = RstButtonDly;
    sq_cfg.sg3_active  = RstSg3Active;
    sq_cfg.pcie_active = RstPcieActive;
    sq_phase    = PH_IDLE;
    sq_timer    = '0;
    sq_elapsed  = '0;
    sq_g3_lvl   = 1'b0;
    sq_pcie_lvl = 1'b1;

    // Hold reset, then release it away from the rising edge
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_values();
    test_full_sequence();
    test_ap_timeout();
    test_zero_timers();
    test_register_extremes();
    test_pause_for_drain();
    test_random_traffic();

    hold_until_drained();
    if (error_cnt == 0 && pin_outcomes_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
src/sg3_pkg.sv
src/sg3_in_if.sv
src/sg3_out_if.sv
src/sg3_cfg_regs.sv
src/sg3_core.sv
src/soft_g3_power_on_sequencer.sv
verif/tb_top.sv
